// ===== rtl/bounded_random_xoshiro128ss_defines.svh =====
// ----------------------------------------------------------------------------
// Bounded random source: assertion macros
// Shared concurrent-assertion shorthands; every user clocks on i_clk and
// holds checks off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_RANDOM_XOSHIRO128SS_DEFINES_SVH
`define BOUNDED_RANDOM_XOSHIRO128SS_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define BRX_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define BRX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/brx_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded random source: shared package
// Word types, seed reset values, config register indexes and the output
// scrambler of the generator.
// ----------------------------------------------------------------------------
`default_nettype none

package brx_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned SEED_COUNT = 4;
    localparam int unsigned CFG_IDX_W  = 3;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Config register indexes
    localparam t_cfg_idx CFG_SEED0 = 3'd0;
    localparam t_cfg_idx CFG_SEED1 = 3'd1;
    localparam t_cfg_idx CFG_SEED2 = 3'd2;
    localparam t_cfg_idx CFG_SEED3 = 3'd3;

    // Seed values after reset
    localparam t_word SEED0_RST = 32'd1;
    localparam t_word SEED1_RST = 32'd2;
    localparam t_word SEED2_RST = 32'd3;
    localparam t_word SEED3_RST = 32'd4;

    // Config write bundle
    typedef struct packed {
        logic     we;
        t_cfg_idx idx;
        t_word    data;
    } t_cfg_wr;

    // Output scrambler: rotl(s1 * 5, 7) * 9, multiplies as shift-adds
    function automatic t_word scramble(input t_word s1);
        t_word m5;
        t_word r7;
        m5 = s1 + {s1[WORD_W-3:0], 2'b00};
        r7 = {m5[WORD_W-8:0], m5[WORD_W-1:WORD_W-7]};
        return r7 + {r7[WORD_W-4:0], 3'b000};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/brx_if.sv =====
// ----------------------------------------------------------------------------
// Bounded random source: stream interfaces
// Request channel carrying the bound and response channel carrying the
// value, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface brx_req_if import brx_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word bound;

    modport source (output valid, output bound, input ready);
    modport sink   (input valid, input bound, output ready);
endinterface

interface brx_rsp_if import brx_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/bounded_random_xoshiro128ss.sv =====
// ----------------------------------------------------------------------------
// Bounded random source: top level
// Returns an unbiased random number below a requested bound, drawn from a
// xoshiro128** generator with rejection sampling.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one bound per beat; o_rsp returns one value per beat.
//   The config port writes seed registers 0 to 3; any seed write reloads
//   the whole generator state. Write seeds only while the block is idle.
//   Bound 0 or 1 returns 0 without a draw.
//   Bound 2^32-1 returns one raw word.
//   Other bounds run the shared 32-step remainder unit twice, once for the
//   rejection threshold and once for the final reduction, redrawing words
//   below the threshold; an all-zero state returns 0 after the threshold.
//   Only one beat is in work at a time; i_req.ready is high while idle,
//   so a new bound is taken only once the last one has gone to the output.
//   The result sits in an output register; a new request is taken while
//   it waits, and a finished result is held until o_rsp.ready frees it.
//   Reset loads seeds 1, 2, 3, 4 into the state and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_random_xoshiro128ss_defines.svh"

module bounded_random_xoshiro128ss import brx_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    brx_req_if.sink                   i_req,
    brx_rsp_if.source                 o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLOOR = 3'd1;
    localparam logic [2:0] S_DRAW  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_word      r_bound;
    t_word      n_bound;
    t_word      r_floor;
    t_word      n_floor;
    t_word      r_res;
    t_word      n_res;
    logic       r_raw;
    logic       n_raw;
    logic       r_out_valid;
    t_word      r_out_value;

    t_cfg_wr    cfg;
    logic       in_fire;
    logic       tiny_bound;
    logic       all_ones;
    logic       out_load;
    logic       gen_step;
    t_word      gen_word;
    logic       gen_zero;
    logic       div_start;
    t_word      div_dvd;
    t_word      div_dsr;
    logic       div_done;
    t_word      div_rem;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign tiny_bound  = (i_req.bound[WORD_W-1:1] == '0);
    assign all_ones    = &i_req.bound;

    brx_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (gen_step),
        .o_word  (gen_word),
        .o_zero  (gen_zero)
    );

    brx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Sequence threshold, draws and reduction
    always_comb begin
        n_state   = r_state;
        n_bound   = r_bound;
        n_floor   = r_floor;
        n_res     = r_res;
        n_raw     = r_raw;
        gen_step  = 1'b0;
        div_start = 1'b0;
        div_dvd   = gen_word;
        div_dsr   = r_bound;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_bound = i_req.bound;
                    n_raw   = all_ones;
                    if (tiny_bound) begin
                        n_res   = '0;
                        n_state = S_PUSH;
                    end else if (all_ones) begin
                        n_state = S_DRAW;
                    end else begin
                        div_start = 1'b1;
                        div_dvd   = '0 - i_req.bound;
                        div_dsr   = i_req.bound;
                        n_state   = S_FLOOR;
                    end
                end
            end
            S_FLOOR: begin
                if (div_done) begin
                    n_floor = div_rem;
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                if (r_raw) begin
                    gen_step = 1'b1;
                    n_res    = gen_word;
                    n_state  = S_PUSH;
                end else if (gen_zero) begin
                    n_res   = '0;
                    n_state = S_PUSH;
                end else begin
                    gen_step = 1'b1;
                    if (gen_word >= r_floor) begin
                        div_start = 1'b1;
                        n_state   = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (div_done) begin
                    n_res   = div_rem;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_bound <= n_bound;
        r_floor <= n_floor;
        r_res   <= n_res;
        r_raw   <= n_raw;
        if (out_load) begin
            r_out_value <= r_res;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_value;

    `BRX_ASSERT_SAME(a_done_expected, div_done, (r_state == S_FLOOR) || (r_state == S_MOD), "remainder done outside a wait state")
    `BRX_ASSERT_SAME(a_res_in_range, (r_state == S_PUSH) && !r_raw, (r_res < r_bound) || ((r_bound[WORD_W-1:1] == '0) && (r_res == '0)), "result not below bound")
    `BRX_ASSERT_NEXT(a_tiny_bound, in_fire && tiny_bound, (r_state == S_PUSH) && (r_res == '0), "bound 0 or 1 not answered with zero")

endmodule

`default_nettype wire

// ===== rtl/brx_gen.sv =====
// ----------------------------------------------------------------------------
// Bounded random source: xoshiro128** generator
// Holds the seed registers and the 128-bit state; reloads the state on any
// seed write and advances it one step on request.
// ----------------------------------------------------------------------------
`default_nettype none

module brx_gen import brx_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_step,
    output logic [WORD_W-1:0] o_word,
    output logic              o_zero
);

    t_word r_seed [SEED_COUNT];
    t_word n_seed [SEED_COUNT];
    t_word r_st   [SEED_COUNT];
    t_word n_st   [SEED_COUNT];
    t_word t2;
    t_word t3;
    logic  seed_wr;

    assign seed_wr = i_cfg.we && (i_cfg.idx <= CFG_SEED3);

    // Update seeds and state
    always_comb begin
        n_seed = r_seed;
        n_st   = r_st;
        t2     = r_st[2] ^ r_st[0];
        t3     = r_st[3] ^ r_st[1];
        if (seed_wr) begin
            n_seed[i_cfg.idx[1:0]] = i_cfg.data;
            n_st = n_seed;
        end else if (i_step) begin
            n_st[0] = r_st[0] ^ t3;
            n_st[1] = r_st[1] ^ t2;
            n_st[2] = t2 ^ {r_st[1][WORD_W-10:0], 9'd0};
            n_st[3] = {t3[WORD_W-12:0], t3[WORD_W-1:WORD_W-11]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed[0] <= SEED0_RST;
            r_seed[1] <= SEED1_RST;
            r_seed[2] <= SEED2_RST;
            r_seed[3] <= SEED3_RST;
            r_st[0]   <= SEED0_RST;
            r_st[1]   <= SEED1_RST;
            r_st[2]   <= SEED2_RST;
            r_st[3]   <= SEED3_RST;
        end else begin
            r_seed <= n_seed;
            r_st   <= n_st;
        end
    end

    // Present the word of the current state
    assign o_word = scramble(r_st[1]);
    assign o_zero = ~|(r_st[0] | r_st[1] | r_st[2] | r_st[3]);

endmodule

`default_nettype wire

// ===== rtl/brx_div.sv =====
// ----------------------------------------------------------------------------
// Bounded random source: remainder unit
// Restoring divider that yields dividend mod divisor, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_random_xoshiro128ss_defines.svh"

module brx_div import brx_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_dividend,
    input  wire logic [WORD_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_rem
);

    localparam int unsigned CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_rem;
    t_word            r_dvd;
    t_word            r_div;
    logic [WORD_W:0]  n_trial;
    logic [WORD_W:0]  n_diff;
    t_word            n_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        n_trial = {r_rem, r_dvd[WORD_W-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_rem   = n_diff[WORD_W] ? n_trial[WORD_W-1:0] : n_diff[WORD_W-1:0];
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `BRX_ASSERT_SAME(a_rem_below_div, r_busy, r_rem < r_div, "remainder reached divisor")
    `BRX_ASSERT_SAME(a_done_at_last, r_done, r_cnt == LAST, "done without full sweep")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded random source: regression bench
// Drives bounds into the request channel, reseeds the generator between
// phases through the config port, and checks every returned value against
// a local xoshiro128** model with rejection sampling. A short table of
// directed rows (trivial bounds, the raw-word bound, rejection-heavy bounds,
// ignored register indexes, all-zero and all-ones seeds) runs first,
// followed by random bounds under three handshake pressure profiles.
// ----------------------------------------------------------------------------
module tb;
    import brx_pkg::*;

    // Indexes past the last seed register: writes there are ignored
    localparam t_cfg_idx CFG_SPARE_LO = CFG_SEED3 + 3'd1;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    localparam int unsigned PHASE_ITEMS   = 200;
    localparam int unsigned RESEED_PERIOD = 50;
    localparam int unsigned DRAIN_CYCLES  = 80;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_cfg_idx  idx;
        t_word     data;
        logic      has_value;
        t_word     value;
    } t_row;

    // Directed rows: bounds go in data; values typed only where obvious
    localparam int unsigned DIR_ROWS = 25;
    localparam t_row DIRECTED [DIR_ROWS] = '{
        // fresh seeds 1, 2, 3, 4: trivial bounds never draw
        '{ROW_REQ, CFG_SEED0, 32'h0000_0000, 1'b1, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'h0000_0001, 1'b1, 32'd0},
        // first raw word of the generator from seeds 1, 2, 3, 4
        '{ROW_REQ, CFG_SEED0, 32'hFFFF_FFFF, 1'b1, 32'd11520},
        '{ROW_REQ, CFG_SEED0, 32'h0000_0002, 1'b0, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'h0000_0003, 1'b0, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'h8000_0000, 1'b0, 32'd0},
        // 8000_0001 sets a threshold near half the word range: many redraws
        '{ROW_REQ, CFG_SEED0, 32'h8000_0001, 1'b0, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'hFFFF_FFFE, 1'b0, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'h5555_5555, 1'b0, 32'd0},
        // writes past the seed registers leave the state running
        '{ROW_CFG, CFG_SPARE_LO, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_CFG, CFG_SPARE_HI, 32'h0000_0000, 1'b0, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'h0000_000A, 1'b0, 32'd0},
        // all-zero state: every value is zero
        '{ROW_CFG, CFG_SEED0, 32'h0000_0000, 1'b0, 32'd0},
        '{ROW_CFG, CFG_SEED1, 32'h0000_0000, 1'b0, 32'd0},
        '{ROW_CFG, CFG_SEED2, 32'h0000_0000, 1'b0, 32'd0},
        '{ROW_CFG, CFG_SEED3, 32'h0000_0000, 1'b0, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'h0000_0007, 1'b1, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'h8000_0001, 1'b1, 32'd0},
        // all-ones seeds
        '{ROW_CFG, CFG_SEED0, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_CFG, CFG_SEED1, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_CFG, CFG_SEED2, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_CFG, CFG_SEED3, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_REQ, CFG_SEED0, 32'hAAAA_AAAA, 1'b0, 32'd0}
    };

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    t_cfg_idx       i_cfg_idx;
    t_word          i_cfg_data;

    brx_req_if req_ch ();
    brx_rsp_if rsp_ch ();

    bounded_random_xoshiro128ss dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Local generator copy and seed shadow
    t_word       seed_shadow [SEED_COUNT];
    t_word       gen_state   [SEED_COUNT];
    t_word       expected_values [$];

    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    int unsigned bounds_sent;
    int unsigned raw_bounds;
    int unsigned trivial_bounds;
    int unsigned seed_writes;
    int unsigned values_checked;
    int unsigned mismatch_count;

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_word rotl32(input t_word v, input int unsigned amount);
        return (v << amount) | (v >> (WORD_W - amount));
    endfunction

    // Advance the generator one step and return its scrambled word
    function automatic t_word next_word();
        t_word word;
        t_word shifted;
        word    = rotl32(gen_state[1] * 32'd5, 7) * 32'd9;
        shifted = gen_state[1] << 9;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= shifted;
        gen_state[3]  = rotl32(gen_state[3], 11);
        return word;
    endfunction

    // Unbiased value below bound: redraw words under 2^32 mod bound
    function automatic t_word draw_bounded(input t_word bound);
        t_word threshold;
        t_word word;
        logic  accepted;
        if (bound <= 32'd1)
            return '0;
        if (bound == '1)
            return next_word();
        threshold = (32'd0 - bound) % bound;
        word      = '0;
        accepted  = 1'b0;
        while (!accepted) begin
            if ((gen_state[0] | gen_state[1] | gen_state[2] | gen_state[3]) == '0) begin
                word     = '0;
                accepted = 1'b1;
            end else begin
                word     = next_word();
                accepted = (word >= threshold);
            end
        end
        return word % bound;
    endfunction

    function automatic t_word pick_bound();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return t_word'($urandom_range(1));
        else if (sel < 10)
            return '1;
        else if (sel < 45)
            return t_word'($urandom_range(64, 2));
        else if (sel < 55)
            return 32'h8000_0000 + t_word'($urandom_range(4096));
        else if (sel < 65)
            return 32'hFFFF_FFFE - t_word'($urandom_range(4096));
        else
            return t_word'($urandom);
    endfunction

    // Offer one bound, hold it until accepted, then queue its value
    task automatic send_bound(input t_word bound, input logic has_value,
                              input t_word value);
        t_word predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.bound <= bound;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        predicted = draw_bounded(bound);
        expected_values.push_back(has_value ? value : predicted);
        bounds_sent++;
        if (bound <= 32'd1)
            trivial_bounds++;
        if (bound == '1)
            raw_bounds++;
    endtask

    // Drop the request, wait for the block to go idle, then write a register
    task automatic write_reg(input t_cfg_idx idx, input t_word data);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx <= CFG_SEED3) begin
            seed_shadow[idx] = data;
            gen_state        = seed_shadow;
        end
        seed_writes++;
    endtask

    // Check each returned beat against the oldest expected value
    always @(posedge i_clk) begin : check_values
        t_word want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_values.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected value beat: got %h", rsp_ch.value);
            end else begin
                want = expected_values.pop_front();
                values_checked++;
                if (rsp_ch.value !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("value mismatch: expected %h, got %h",
                                 want, rsp_ch.value);
                end
            end
        end
    end

    // Randomize the receiver each cycle
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    initial begin : stimulus
        int unsigned idle_sender [3];
        int unsigned idle_receiver [3];
        int unsigned i;
        int unsigned p;
        idle_sender   = '{19, 77, 0};
        idle_receiver = '{77, 19, 0};

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_SEED0;
        i_cfg_data   = '0;
        req_ch.valid = 1'b0;
        req_ch.bound = '0;
        sender_idle_pct   = idle_sender[0];
        receiver_idle_pct = idle_receiver[0];
        bounds_sent    = 0;
        raw_bounds     = 0;
        trivial_bounds = 0;
        seed_writes    = 0;
        values_checked = 0;
        mismatch_count = 0;
        seed_shadow = '{SEED0_RST, SEED1_RST, SEED2_RST, SEED3_RST};
        gen_state   = seed_shadow;

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows
        for (i = 0; i < DIR_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            else
                send_bound(DIRECTED[i].data, DIRECTED[i].has_value, DIRECTED[i].value);
        end

        // Random bounds under each pressure profile, reseeding as we go
        for (p = 0; p < 3; p++) begin
            sender_idle_pct   = idle_sender[p];
            receiver_idle_pct = idle_receiver[p];
            write_reg(CFG_SEED0, t_word'($urandom));
            write_reg(CFG_SEED1, t_word'($urandom));
            write_reg(CFG_SEED2, t_word'($urandom));
            write_reg(CFG_SEED3, t_word'($urandom));
            write_reg(t_cfg_idx'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                      t_word'($urandom));
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i != 0 && i % RESEED_PERIOD == 0)
                    write_reg(t_cfg_idx'($urandom_range(CFG_SEED0, CFG_SPARE_HI)),
                              t_word'($urandom));
                send_bound(pick_bound(), 1'b0, '0);
            end
        end

        // Drain and watch for stray beats
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bounds (%0d trivial, %0d raw) and %0d register writes",
                 bounds_sent, trivial_bounds, raw_bounds, seed_writes);
        $display("compared %0d values over three handshake profiles, %0d mismatches",
                 values_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("bounded_random_xoshiro128ss regression: pass");
        else
            $display("bounded_random_xoshiro128ss regression: fail");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #(15_000_000);
        $display("timeout: %0d values still expected", expected_values.size());
        $display("bounded_random_xoshiro128ss regression: fail");
        $finish;
    end

endmodule
